// ----- rtl/core/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// shared types and constants of the lru pair cache: request and result
// payloads, operation and status codes, controller to datapath signals
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 5;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_GET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [KEY_W-1:0]  key;
    logic signed [KEY_W-1:0]  value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;
    logic signed [KEY_W-1:0]  evicted_value;
  } out_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic pass2;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic issue_done;
    logic need_update;
  } sts_t;

endpackage

// ----- rtl/core/lpc_ram.sv -----
// ----------------------------------------------------------------------------
// lpc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpc_ctrl
// request sequencer: scan pass over the slots, decision, rank update pass,
// result strobe
// ----------------------------------------------------------------------------
module lpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  lpc_pkg::kind_t kind,
  output logic          busy,
  output lpc_pkg::cmd_t cmd,
  input  lpc_pkg::sts_t sts,
  output logic          out_valid
);
  import lpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (kind) inside
            KIND_ADD, KIND_GET: state_nxt = S_SCAN;
            KIND_CLEAR:         state_nxt = S_DONE;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue = !sts.issue_done;
        if (sts.issue_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.need_update ? S_UPDATE : S_DONE;
      end
      S_UPDATE: begin
        cmd.issue = !sts.issue_done;
        cmd.pass2 = 1'b1;
        if (sts.issue_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while busy");

  a_decide_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> $past(state_r == S_SCAN))
    else $error("decision without a completed scan");

endmodule

// ----- rtl/core/lpc_dpath.sv -----
// ----------------------------------------------------------------------------
// lpc_dpath
// slot storage and scan datapath: pair and rank rams, valid bits, occupancy,
// capacity register, match and victim search, rank update, result register
// ----------------------------------------------------------------------------
module lpc_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpc_pkg::in_t                in_req,
  input  lpc_pkg::cmd_t               cmd,
  output lpc_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [lpc_pkg::CAP_W-1:0]   cfg_data,
  output lpc_pkg::out_t               out_res
);
  import lpc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = AW;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int EW = (OW > CAP_W) ? OW : CAP_W;
  localparam int PW = 2 * KEY_W;

  in_t              req_r;
  logic [AW:0]      idx_r;
  logic             rd_vld_r;
  logic             rd_pass2_r;
  logic [AW-1:0]    rd_idx_r;
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic [OW-1:0]    occ_r;
  logic [CAP_W-1:0] cap_r;

  logic             found_r;
  logic [AW-1:0]    hit_idx_r;
  logic [RW-1:0]    hit_rank_r;
  logic             vic_found_r;
  logic [AW-1:0]    vic_idx_r;
  logic [RW-1:0]    vic_rank_r;
  logic [PW-1:0]    vic_pair_r;
  logic             free_found_r;
  logic [AW-1:0]    free_idx_r;
  logic [AW-1:0]    tgt_r;
  logic             evict_r;
  out_t             out_r, out_nxt;

  logic [PW-1:0]    pair_rdata;
  logic [RW-1:0]    rank_rdata;
  logic             pair_we;
  logic             rank_we;
  logic [AW-1:0]    rank_waddr;
  logic [RW-1:0]    rank_wdata;

  logic             cur_valid;
  logic             match;
  logic             is_add;
  logic             is_get;
  logic [EW-1:0]    occ_ext;
  logic [EW-1:0]    cap_ext;
  logic [EW-1:0]    eff_cap;
  logic             full;
  logic             evict_now;
  logic             do_insert;
  logic [AW-1:0]    tgt_now;
  logic             need_update;
  logic             p2_we;

  lpc_ram #(.WIDTH(PW), .DEPTH(DEPTH), .AW(AW)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (tgt_now),
    .wdata ({req_r.key, req_r.value}),
    .raddr (idx_r[AW-1:0]),
    .rdata (pair_rdata)
  );

  lpc_ram #(.WIDTH(RW), .DEPTH(DEPTH), .AW(AW)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rank_rdata)
  );

  // effective capacity: zero means one, above depth saturates
  always_comb begin
    occ_ext = EW'(occ_r);
    cap_ext = EW'(cap_r);
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    full = (occ_ext >= eff_cap);
  end

  assign cur_valid = valid_r[rd_idx_r];
  assign match     = cur_valid && (pair_rdata == {req_r.key, req_r.value});
  assign is_add    = (req_r.kind == KIND_ADD);
  assign is_get    = (req_r.kind == KIND_GET);

  assign need_update = (is_add && !found_r) || (is_get && found_r);
  assign evict_now   = is_add && !found_r && full && vic_found_r;
  assign do_insert   = cmd.decide && is_add && !found_r;

  // target slot: first free slot after the victim is released, else the hit slot
  always_comb begin
    if (evict_now) begin
      tgt_now = (free_found_r && (free_idx_r < vic_idx_r)) ? free_idx_r : vic_idx_r;
    end else if (is_add) begin
      tgt_now = free_idx_r;
    end else begin
      tgt_now = hit_idx_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.decide) begin
      if (evict_now) begin
        valid_nxt[vic_idx_r] = 1'b0;
      end
      if (do_insert) begin
        valid_nxt[tgt_now] = 1'b1;
      end
    end
    if (cmd.finish && (req_r.kind == KIND_CLEAR)) begin
      valid_nxt = '0;
    end
  end

  assign p2_we = rd_vld_r && rd_pass2_r && cur_valid && (rd_idx_r != tgt_r) &&
                 (is_add || (rank_rdata < hit_rank_r));

  assign pair_we    = do_insert;
  assign rank_we    = (cmd.decide && need_update) || p2_we;
  assign rank_waddr = cmd.decide ? tgt_now : rd_idx_r;
  assign rank_wdata = cmd.decide ? '0 : rank_rdata + RW'(1);

  always_comb begin
    out_nxt = '0;
    case (req_r.kind)
      KIND_ADD: out_nxt.status = found_r ? ST_DUPLICATE : ST_INSERTED;
      KIND_GET: out_nxt.status = found_r ? ST_FOUND : ST_NOT_FOUND;
      default:  out_nxt.status = ST_CLEARED;
    endcase
    out_nxt.evicted       = evict_r;
    out_nxt.evicted_key   = evict_r ? vic_pair_r[PW-1:KEY_W] : '0;
    out_nxt.evicted_value = evict_r ? vic_pair_r[KEY_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      occ_r    <= '0;
      cap_r    <= CAP_W'(DEPTH);
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      rd_vld_r <= cmd.issue;
      if (cmd.load || cmd.decide) begin
        idx_r <= '0;
      end else if (cmd.issue) begin
        idx_r <= idx_r + (AW+1)'(1);
      end
      valid_r <= valid_nxt;
      if (cmd.decide) begin
        occ_r <= occ_r - OW'(evict_now) + OW'(do_insert);
      end
      if (cmd.finish && (req_r.kind == KIND_CLEAR)) begin
        occ_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_pass2_r <= cmd.pass2;
    rd_idx_r   <= idx_r[AW-1:0];
    if (cmd.load) begin
      req_r        <= in_req;
      found_r      <= 1'b0;
      vic_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      evict_r      <= 1'b0;
    end
    if (rd_vld_r && !rd_pass2_r) begin
      if (match && !found_r) begin
        found_r    <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_rank_r <= rank_rdata;
      end
      if (cur_valid && (!vic_found_r || (rank_rdata > vic_rank_r))) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= rd_idx_r;
        vic_rank_r  <= rank_rdata;
        vic_pair_r  <= pair_rdata;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
    if (cmd.decide) begin
      tgt_r   <= tgt_now;
      evict_r <= evict_now;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign sts.issue_done  = (idx_r == (AW+1)'(DEPTH));
  assign sts.need_update = need_update;
  assign out_res         = out_r;

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == occ_r)
    else $error("occupancy does not match valid slots");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH))
    else $error("occupancy above depth");

  a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && evict_now) |-> valid_r[vic_idx_r])
    else $error("eviction of an empty slot");

endmodule

// ----- rtl/core/lru_pair_cache.sv -----
// ----------------------------------------------------------------------------
// lru_pair_cache
// least recently used store of (key, value) pairs with eviction report
// ----------------------------------------------------------------------------
// a request (in_req: kind, key, value) is taken when start is high and busy is
// low. kind add inserts the pair as most recent, evicting the least recent
// pair when the store holds capacity pairs; an add of a pair already present
// is rejected. kind get looks the pair up and makes a hit most recent. kind
// clear empties the store. the fourth kind code is taken and does nothing.
// each add, get or clear gives one result on out_res, marked by out_valid for
// exactly one cycle; the receiver has no way to hold it off.
// an add or get walks the slot rams one address per cycle: a scan pass, a
// decision, and for an insert or a hit a rank update pass, then the result
// is registered; a clear only registers its result. busy stays high until
// the result is registered; out_valid is high in the cycle busy falls, when
// the next request may already be taken. capacity is written through
// cfg_valid/cfg_data; the user must write it only while idle, the block
// itself does not enforce this. cfg_ready is always high. reset empties the
// store and sets capacity to DEPTH.
// ----------------------------------------------------------------------------
module lru_pair_cache #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lpc_pkg::in_t              in_req,
  output logic                      out_valid,
  output lpc_pkg::out_t             out_res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lpc_pkg::CAP_W-1:0] cfg_data
);
  import lpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_req.kind),
    .busy      (busy),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid)
  );

  lpc_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_res  (out_res)
  );

endmodule

// ----- sim/tb_lru_pair_cache.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_pair_cache
// self-checking bench for the lru pair cache. a queue of requests and
// capacity writes feeds a clocked driver with random gaps. every accepted
// request runs through a local recency model that predicts status and any
// evicted pair. a clocked monitor checks each result strobe against the
// oldest prediction. a directed opening covers empty lookups, duplicates,
// shared keys, field extremes, clear and the capacity corner values. random
// phases follow, each at its own capacity, some of them below the current
// fill so that every add of a new pair has to evict.
// ----------------------------------------------------------------------------
module tb_lru_pair_cache;
  import lpc_pkg::*;

  localparam int DEPTH    = 16;
  localparam int SETTLE   = 2 * DEPTH + 8;
  localparam int LIMIT    = 600000;
  localparam int N_RANDOM = 1164;
  localparam int N_PHASES = 12;

  localparam logic [KEY_W-1:0] K_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] K_MAX = 32'h7fff_ffff;

  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] cap;
    in_t              req;
    int unsigned      gap;
  } op_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_t              in_req    = '0;
  logic             out_valid;
  out_t             out_res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  op_t  pending_ops[$];
  out_t cache_answers[$];

  // recency model of the store
  logic [KEY_W-1:0] slot_k[DEPTH];
  logic [KEY_W-1:0] slot_v[DEPTH];
  bit               slot_used[DEPTH];
  int unsigned      slot_age[DEPTH];
  int unsigned      fill_cnt = 0;
  logic [CAP_W-1:0] cap_reg  = CAP_W'(DEPTH);

  int unsigned gap_max = 19;
  logic [KEY_W-1:0] pool_key[5];
  logic [KEY_W-1:0] pool_val[5];

  bit          nxt_start;
  bit          nxt_cfg;
  bit          gap_loaded = 1'b0;
  int unsigned hold       = 0;
  int unsigned quiet      = 0;
  out_t        drv_res;
  out_t        want;

  int unsigned cycles  = 0;
  int unsigned errors  = 0;
  int unsigned n_add   = 0;
  int unsigned n_dup   = 0;
  int unsigned n_evict = 0;
  int unsigned n_get   = 0;
  int unsigned n_hit   = 0;
  int unsigned n_clear = 0;
  int unsigned n_cfg   = 0;

  lru_pair_cache #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit cache_apply(input in_t r, output out_t res);
    int hit;
    int victim;
    int slot;
    int unsigned lim;
    int unsigned age;
    res = '0;
    hit = -1;
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && slot_k[i] == r.key && slot_v[i] == r.value) hit = i;
    lim = (cap_reg == '0) ? 1 : (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    case (r.kind)
      KIND_ADD: begin
        n_add++;
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
          n_dup++;
        end else begin
          if (fill_cnt >= lim) begin
            victim = -1;
            for (int i = 0; i < DEPTH; i++)
              if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
            if (victim >= 0) begin
              res.evicted       = 1'b1;
              res.evicted_key   = slot_k[victim];
              res.evicted_value = slot_v[victim];
              slot_used[victim] = 1'b0;
              slot_age[victim]  = 0;
              fill_cnt--;
              n_evict++;
            end
          end
          slot = -1;
          for (int i = DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < DEPTH; i++)
              if (slot_used[i]) slot_age[i]++;
            slot_k[slot]    = r.key;
            slot_v[slot]    = r.value;
            slot_used[slot] = 1'b1;
            slot_age[slot]  = 0;
            fill_cnt++;
          end
          res.status = ST_INSERTED;
        end
      end
      KIND_GET: begin
        n_get++;
        if (hit >= 0) begin
          age = slot_age[hit];
          for (int i = 0; i < DEPTH; i++)
            if (slot_used[i] && slot_age[i] < age) slot_age[i]++;
          slot_age[hit] = 0;
          res.status = ST_FOUND;
          n_hit++;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      KIND_CLEAR: begin
        n_clear++;
        for (int i = 0; i < DEPTH; i++) begin
          slot_used[i] = 1'b0;
          slot_age[i]  = 0;
        end
        fill_cnt = 0;
        res.status = ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void push_req(input kind_t k, input logic [KEY_W-1:0] key,
                                   input logic [KEY_W-1:0] val);
    op_t op;
    op.is_cfg    = 1'b0;
    op.cap       = '0;
    op.req.kind  = k;
    op.req.key   = key;
    op.req.value = val;
    op.gap       = $urandom_range(0, gap_max);
    pending_ops.push_back(op);
  endfunction

  function automatic void push_cap(input logic [CAP_W-1:0] cap);
    op_t op;
    op.is_cfg = 1'b1;
    op.cap    = cap;
    op.req    = '0;
    op.gap    = 0;
    pending_ops.push_back(op);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        if (cache_apply(in_req, drv_res)) cache_answers.push_back(drv_res);
        nxt_start = 1'b0;
        quiet     = 0;
      end else if (quiet < SETTLE) begin
        quiet++;
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        n_cfg++;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && pending_ops.size() != 0) begin
        if (!gap_loaded) begin
          hold       = pending_ops[0].gap;
          gap_loaded = 1'b1;
        end
        if (hold != 0) begin
          hold--;
        end else if (!pending_ops[0].is_cfg) begin
          in_req    <= pending_ops[0].req;
          nxt_start  = 1'b1;
          gap_loaded = 1'b0;
          void'(pending_ops.pop_front());
        end else if (cache_answers.size() == 0 && quiet >= SETTLE && !busy) begin
          // capacity only changes with the store idle
          cfg_data  <= pending_ops[0].cap;
          nxt_cfg    = 1'b1;
          gap_loaded = 1'b0;
          void'(pending_ops.pop_front());
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cache_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d evicted %0b key %h value %h",
                   out_res.status, out_res.evicted, out_res.evicted_key,
                   out_res.evicted_value);
      end else begin
        want = cache_answers.pop_front();
        if (out_res.status !== want.status || out_res.evicted !== want.evicted ||
            out_res.evicted_key !== want.evicted_key ||
            out_res.evicted_value !== want.evicted_value) begin
          errors++;
          if (errors <= 10) begin
            $write("mismatch at cycle %0d (expected/actual): status %0d/%0d evicted %0b/%0b",
                   cycles, want.status, out_res.status, want.evicted, out_res.evicted);
            $display(" key %h/%h value %h/%h", want.evicted_key, out_res.evicted_key,
                     want.evicted_value, out_res.evicted_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout: %0d requests queued, %0d results outstanding",
               pending_ops.size(), cache_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap_plan[N_PHASES];
    int unsigned      done;
    int unsigned      sel;
    int unsigned      clear_pct;
    kind_t            k;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] val;

    cap_plan    = '{5'd31, 5'd4, 5'd16, 5'd2, 5'd17, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8,
                    5'd15, 5'd0};
    pool_key    = '{K_MIN, K_MAX, 32'h0, 32'hffff_ffff, 32'h0};
    pool_val    = '{K_MIN, K_MAX, 32'h0, 32'h1, 32'h0};
    pool_key[4] = $urandom;
    pool_val[4] = $urandom;

    // directed opening at the reset capacity
    push_req(KIND_GET, '0, '0);
    push_req(KIND_ADD, K_MIN, K_MAX);
    push_req(KIND_ADD, K_MIN, K_MAX);
    push_req(KIND_ADD, K_MAX, K_MIN);
    push_req(KIND_ADD, K_MIN, K_MIN);
    push_req(KIND_GET, K_MAX, K_MIN);
    push_req(KIND_GET, K_MAX, K_MAX);
    push_req(KIND_NOP, $urandom, $urandom);
    push_req(KIND_ADD, '0, '1);
    push_req(KIND_ADD, '1, '0);
    push_req(KIND_CLEAR, $urandom, $urandom);
    push_req(KIND_GET, K_MIN, K_MAX);
    push_req(KIND_ADD, 32'd1, 32'd1);
    // capacity one, then zero which acts as one
    push_cap(5'd1);
    push_req(KIND_ADD, 32'd2, 32'd2);
    push_req(KIND_ADD, 32'd2, 32'd2);
    push_req(KIND_GET, 32'd1, 32'd1);
    push_req(KIND_ADD, K_MAX, K_MAX);
    push_cap(5'd0);
    push_req(KIND_ADD, 32'd3, 32'd3);
    push_req(KIND_GET, 32'd3, 32'd3);

    // random phases, each with its own capacity and idling style
    for (int ph = 0; ph < N_PHASES; ph++) begin
      push_cap(ph == N_PHASES - 1 ? 5'($urandom_range(0, 31)) : cap_plan[ph]);
      gap_max     = (ph % 3 == 2) ? 0 : 19;
      clear_pct   = (ph % 2 == 1) ? 3 : 0;
      pool_key[4] = $urandom;
      pool_val[4] = $urandom;
      done = 0;
      while (done < N_RANDOM / N_PHASES) begin
        if ($urandom_range(0, 9) == 0) begin
          key = $urandom;
          val = $urandom;
        end else begin
          key = pool_key[$urandom_range(0, 4)];
          val = pool_val[$urandom_range(0, 4)];
        end
        sel = $urandom_range(0, 99);
        if (sel < clear_pct) k = KIND_CLEAR;
        else if (sel < clear_pct + 5) k = KIND_NOP;
        else if (sel < clear_pct + 55) k = KIND_ADD;
        else k = KIND_GET;
        push_req(k, key, val);
        if (k != KIND_NOP) done++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || start || cfg_valid || cache_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d adds (%0d duplicates, %0d evictions) and %0d gets (%0d hits)",
             n_add, n_dup, n_evict, n_get, n_hit);
    $display("%0d clears, capacity written %0d times, %0d mismatches in %0d cycles",
             n_clear, n_cfg, errors, cycles);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lpc_pkg.sv
rtl/core/lpc_ram.sv
rtl/core/lpc_ctrl.sv
rtl/core/lpc_dpath.sv
rtl/core/lru_pair_cache.sv
sim/tb_lru_pair_cache.sv
